// File: src/atilt_pkg.sv
// ============================================================================
// atilt_pkg
// Shared widths, sideband types and the arctangent table for the tilt pipeline.
// ============================================================================
`default_nettype none

package atilt_pkg;

	localparam int NW       = 31;          // normalized magnitude bits
	localparam int SW       = 2 * NW + 1;  // sum of two squares
	localparam int RTW      = 32;          // square root bits
	localparam int SQ_STEPS = 32;          // root bits resolved, one per stage
	localparam int GUARD    = 24;          // cordic guard bits
	localparam int CW       = 60;          // cordic x / y width, signed
	localparam int STEPS    = 34;          // cordic micro-rotations
	localparam int ANGLE_Q  = 34;          // angle fraction bits, radians
	localparam int ACC_W    = 37;          // angle accumulator, signed
	localparam int DEG_Q    = 24;          // fraction bits of the degree scale
	localparam int TILT_W   = 16;

	localparam logic [29:0] DEG_PER_RAD = 30'd961263669;  // 180/pi, q24

	typedef logic [NW-1:0] mag_t;
	typedef mag_t [2:0] mag3_t;

	typedef struct packed {
		logic [2:0] neg;
		logic       zero;
	} flags_t;

	// atan(2^-i) in radians, 34 fraction bits, rounded
	function automatic logic [ACC_W-1:0] atan_entry(input int i);
		logic [ACC_W-1:0] e;
		unique case (i)
			1:       e = 37'd7965405270;
			2:       e = 37'd4208701385;
			3:       e = 37'd2136402539;
			4:       e = 37'd1072346990;
			5:       e = 37'd536696252;
			6:       e = 37'd268413614;
			7:       e = 37'd134214997;
			8:       e = 37'd67108523;
			9:       e = 37'd33554389;
			10:      e = 37'd16777211;
			11:      e = 37'd8388607;
			default: e = ACC_W'(64'd1 << (ANGLE_Q - i));
		endcase
		return e;
	endfunction

endpackage

`default_nettype wire

// File: src/atilt_ifs.sv
// ============================================================================
// atilt_ifs
// Valid / ready channels for accelerometer samples and tilt angle results.
// ============================================================================
`default_nettype none

interface atilt_in_if #(
	parameter int ACCEL_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [ACCEL_WIDTH-1:0] accel_x;
	logic signed [ACCEL_WIDTH-1:0] accel_y;
	logic signed [ACCEL_WIDTH-1:0] accel_z;

	modport source(output valid, accel_x, accel_y, accel_z, input ready);
	modport sink(input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atilt_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [atilt_pkg::TILT_W-1:0] tilt_x;
	logic signed [atilt_pkg::TILT_W-1:0] tilt_y;
	logic signed [atilt_pkg::TILT_W-1:0] tilt_z;
	logic [2:0]                         undefined_mask;

	modport source(output valid, tilt_x, tilt_y, tilt_z, undefined_mask, input ready);
	modport sink(input valid, tilt_x, tilt_y, tilt_z, undefined_mask, output ready);
endinterface

`default_nettype wire

// File: src/atilt_norm.sv
// ============================================================================
// atilt_norm
// Magnitudes, joint normalization and sums of squares, five stages.
// ============================================================================
`default_nettype none

module atilt_norm #(
	parameter int ACCEL_WIDTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   en,
	input  wire logic                                   in_vld,
	input  wire logic [2:0][ACCEL_WIDTH-1:0]            accel,
	output logic                                        out_vld,
	output logic [2:0][atilt_pkg::SW-1:0]               rad,
	output atilt_pkg::mag3_t                            mag,
	output atilt_pkg::flags_t                           flags
);

	logic                                vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [2:0][31:0]                    mag_s1, mag_s2;
	logic [2:0]                          neg_s1;
	atilt_pkg::flags_t                   flg_s2, flg_s3, flg_s4, flg_s5;
	logic                                shr_s2;
	logic [4:0]                          shl_s2;
	atilt_pkg::mag3_t                    u_s3, u_s4, u_s5;
	logic [2:0][2*atilt_pkg::NW-1:0]     sq_s4;
	logic [2:0][atilt_pkg::SW-1:0]       rad_s5;

	logic [2:0][31:0]                    mag_c;
	logic [2:0]                          neg_c;
	logic [31:0]                         max_c;
	logic [4:0]                          msb_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			neg_c[k] = accel[k][ACCEL_WIDTH-1];
			mag_c[k] = 32'(neg_c[k] ? ACCEL_WIDTH'(~accel[k] + ACCEL_WIDTH'(1))
				: accel[k]);
		end
	end

	// largest magnitude and its leading one
	always_comb begin
		max_c = mag_s1[0];
		if (mag_s1[1] > max_c) max_c = mag_s1[1];
		if (mag_s1[2] > max_c) max_c = mag_s1[2];
		msb_c = '0;
		for (int i = 0; i < 32; i++) begin
			if (max_c[i]) msb_c = 5'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1          <= mag_c;
			neg_s1          <= neg_c;

			mag_s2          <= mag_s1;
			flg_s2.neg      <= neg_s1;
			flg_s2.zero     <= (max_c == '0);
			shr_s2          <= max_c[31];
			shl_s2          <= 5'd30 - msb_c;

			flg_s3          <= flg_s2;
			for (int k = 0; k < 3; k++) begin
				u_s3[k] <= shr_s2 ? atilt_pkg::NW'(mag_s2[k] >> 1)
					: atilt_pkg::NW'(mag_s2[k] << shl_s2);
			end

			flg_s4          <= flg_s3;
			u_s4            <= u_s3;
			for (int k = 0; k < 3; k++) begin
				sq_s4[k] <= (2*atilt_pkg::NW)'(u_s3[k]) * (2*atilt_pkg::NW)'(u_s3[k]);
			end

			flg_s5          <= flg_s4;
			u_s5            <= u_s4;
			rad_s5[0]       <= atilt_pkg::SW'(sq_s4[1]) + atilt_pkg::SW'(sq_s4[2]);
			rad_s5[1]       <= atilt_pkg::SW'(sq_s4[0]) + atilt_pkg::SW'(sq_s4[2]);
			rad_s5[2]       <= atilt_pkg::SW'(sq_s4[0]) + atilt_pkg::SW'(sq_s4[1]);
		end
	end

	assign out_vld = vld_s5;
	assign rad     = rad_s5;
	assign mag     = u_s5;
	assign flags   = flg_s5;

endmodule

`default_nettype wire

// File: src/atilt_isqrt.sv
// ============================================================================
// atilt_isqrt
// Three-lane floor square root, one result bit per pipeline stage.
// ============================================================================
`default_nettype none

module atilt_isqrt (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   en,
	input  wire logic                                   in_vld,
	input  wire logic [2:0][atilt_pkg::SW-1:0]          rad,
	input  wire atilt_pkg::mag3_t                       mag_in,
	input  wire atilt_pkg::flags_t                      flags_in,
	output logic                                        out_vld,
	output logic [2:0][atilt_pkg::RTW-1:0]              root,
	output atilt_pkg::mag3_t                            mag_out,
	output atilt_pkg::flags_t                           flags_out
);

	localparam int N = atilt_pkg::SQ_STEPS;

	logic                              vld_s  [N];
	logic [2:0][atilt_pkg::SW-1:0]     rem_s  [N];
	logic [2:0][atilt_pkg::SW-1:0]     root_s [N];
	atilt_pkg::mag3_t                  mag_s  [N];
	atilt_pkg::flags_t                 flg_s  [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [atilt_pkg::SW-1:0] BITV =
			atilt_pkg::SW'(1) << (atilt_pkg::SW - 1 - 2 * k);

		logic                          vld_c;
		logic [2:0][atilt_pkg::SW-1:0] rem_c, root_c, trial_c, rem_n, root_n;
		atilt_pkg::mag3_t              mag_c;
		atilt_pkg::flags_t             flg_c;

		if (k == 0) begin : g_first
			assign vld_c  = in_vld;
			assign rem_c  = rad;
			assign root_c = '0;
			assign mag_c  = mag_in;
			assign flg_c  = flags_in;
		end else begin : g_next
			assign vld_c  = vld_s[k-1];
			assign rem_c  = rem_s[k-1];
			assign root_c = root_s[k-1];
			assign mag_c  = mag_s[k-1];
			assign flg_c  = flg_s[k-1];
		end

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				trial_c[l] = root_c[l] + BITV;
				if (rem_c[l] >= trial_c[l]) begin
					rem_n[l]  = rem_c[l] - trial_c[l];
					root_n[l] = (root_c[l] >> 1) + BITV;
				end else begin
					rem_n[l]  = rem_c[l];
					root_n[l] = root_c[l] >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_n;
				root_s[k] <= root_n;
				mag_s[k]  <= mag_c;
				flg_s[k]  <= flg_c;
			end
		end
	end

	assign out_vld = vld_s[N-1];
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			root[l] = atilt_pkg::RTW'(root_s[N-1][l]);
		end
	end
	assign mag_out   = mag_s[N-1];
	assign flags_out = flg_s[N-1];

endmodule

`default_nettype wire

// File: src/atilt_cordic.sv
// ============================================================================
// atilt_cordic
// Three-lane vectoring cordic, first-octant angle in radians, one rotation a stage.
// ============================================================================
`default_nettype none

module atilt_cordic (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   en,
	input  wire logic                                   in_vld,
	input  wire logic [2:0][atilt_pkg::RTW-1:0]         num,
	input  wire logic [2:0][atilt_pkg::RTW-1:0]         den,
	input  wire atilt_pkg::flags_t                      flags_in,
	output logic                                        out_vld,
	output logic signed [2:0][atilt_pkg::ACC_W-1:0]     acc,
	output logic [2:0]                                  swp,
	output atilt_pkg::flags_t                           flags_out
);

	localparam int N  = atilt_pkg::STEPS;
	localparam int CW = atilt_pkg::CW;
	localparam int AW = atilt_pkg::ACC_W;

	logic                          vld_s [N+1];
	logic signed [2:0][CW-1:0]     x_s   [N+1];
	logic signed [2:0][CW-1:0]     y_s   [N+1];
	logic signed [2:0][AW-1:0]     acc_s [N+1];
	logic [2:0]                    swp_s [N+1];
	atilt_pkg::flags_t             flg_s [N+1];

	// entry: reduce to smaller over larger
	logic [2:0]                    swp_c;
	logic [2:0][atilt_pkg::RTW-1:0] hi_c, lo_c;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			swp_c[l] = num[l] > den[l];
			hi_c[l]  = swp_c[l] ? num[l] : den[l];
			lo_c[l]  = swp_c[l] ? den[l] : num[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				x_s[0][l]   <= CW'(hi_c[l]) << atilt_pkg::GUARD;
				y_s[0][l]   <= CW'(lo_c[l]) << atilt_pkg::GUARD;
				acc_s[0][l] <= '0;
			end
			swp_s[0] <= swp_c;
			flg_s[0] <= flags_in;
		end
	end

	for (genvar i = 1; i <= N; i++) begin : g_rot
		localparam logic signed [AW-1:0] ANG = atilt_pkg::atan_entry(i);

		logic signed [2:0][CW-1:0] x_n, y_n;
		logic signed [2:0][AW-1:0] acc_n;

		// lane selects of a packed array are unsigned, so shifts go through $signed
		always_comb begin
			for (int l = 0; l < 3; l++) begin
				if (!y_s[i-1][l][CW-1]) begin
					x_n[l]   = $signed(x_s[i-1][l]) + ($signed(y_s[i-1][l]) >>> i);
					y_n[l]   = $signed(y_s[i-1][l]) - ($signed(x_s[i-1][l]) >>> i);
					acc_n[l] = acc_s[i-1][l] + ANG;
				end else begin
					x_n[l]   = $signed(x_s[i-1][l]) - ($signed(y_s[i-1][l]) >>> i);
					y_n[l]   = $signed(y_s[i-1][l]) + ($signed(x_s[i-1][l]) >>> i);
					acc_n[l] = acc_s[i-1][l] - ANG;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i]   <= x_n;
				y_s[i]   <= y_n;
				acc_s[i] <= acc_n;
				swp_s[i] <= swp_s[i-1];
				flg_s[i] <= flg_s[i-1];
			end
		end
	end

	assign out_vld   = vld_s[N];
	assign acc       = acc_s[N];
	assign swp       = swp_s[N];
	assign flags_out = flg_s[N];

endmodule

`default_nettype wire

// File: src/atilt_scale.sv
// ============================================================================
// atilt_scale
// Radians to rounded degrees, octant fold, sign and saturation; holds the result.
// ============================================================================
`default_nettype none

module atilt_scale #(
	parameter int ANGLE_FRAC_BITS = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   en,
	input  wire logic                                   in_vld,
	input  wire logic signed [2:0][atilt_pkg::ACC_W-1:0] acc,
	input  wire logic [2:0]                             swp,
	input  wire atilt_pkg::flags_t                      flags,
	output logic                                        out_vld,
	output logic signed [2:0][atilt_pkg::TILT_W-1:0]    tilt,
	output logic [2:0]                                  mask
);

	localparam int AMW  = atilt_pkg::ANGLE_Q + 1;        // clamped angle
	localparam int LOW  = 18;
	localparam int HIW  = AMW - LOW;
	localparam int KW   = 30;
	localparam int PW   = AMW + KW;
	localparam int SH   = atilt_pkg::ANGLE_Q + atilt_pkg::DEG_Q - ANGLE_FRAC_BITS;
	localparam int RW   = PW + 1 - SH;
	localparam logic [RW-1:0] RIGHT = RW'(90 << ANGLE_FRAC_BITS);
	localparam int TMAX = (1 << (atilt_pkg::TILT_W - 1)) - 1;

	logic                               vld_s1, vld_s2, vld_s3;
	logic [2:0][LOW+KW-1:0]             pl_s1;
	logic [2:0][HIW+KW-1:0]             ph_s1;
	logic [2:0]                         swp_s1, swp_s2;
	atilt_pkg::flags_t                  flg_s1, flg_s2;
	logic [2:0][RW-1:0]                 r_s2;
	logic signed [2:0][atilt_pkg::TILT_W-1:0] tilt_s3;
	logic [2:0]                         mask_s3;

	logic [2:0][AMW-1:0]                a_c;
	logic [2:0][PW:0]                   sum_c;
	logic [2:0][RW-1:0]                 fold_c;
	logic signed [2:0][31:0]            sv_c;
	logic signed [2:0][atilt_pkg::TILT_W-1:0] sat_c;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			a_c[l] = acc[l][atilt_pkg::ACC_W-1] ? '0 : acc[l][AMW-1:0];
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			sum_c[l] = ((PW+1)'(ph_s1[l]) << LOW) + (PW+1)'(pl_s1[l])
				+ ((PW+1)'(1) << (SH - 1));
		end
	end

	// fold back the swapped octant, apply sign, clip to the output range
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			fold_c[l] = swp_s2[l] ? (RIGHT - r_s2[l]) : r_s2[l];
			sv_c[l]   = flg_s2.neg[l] ? -$signed(32'(fold_c[l])) : $signed(32'(fold_c[l]));
			if ($signed(sv_c[l]) > 32'sd0 + TMAX) begin
				sat_c[l] = atilt_pkg::TILT_W'(TMAX);
			end else if ($signed(sv_c[l]) < -32'sd1 - TMAX) begin
				sat_c[l] = atilt_pkg::TILT_W'(-1 - TMAX);
			end else begin
				sat_c[l] = sv_c[l][atilt_pkg::TILT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				pl_s1[l] <= (LOW+KW)'(a_c[l][LOW-1:0]) * (LOW+KW)'(atilt_pkg::DEG_PER_RAD);
				ph_s1[l] <= (HIW+KW)'(a_c[l][AMW-1:LOW]) * (HIW+KW)'(atilt_pkg::DEG_PER_RAD);
				r_s2[l]  <= RW'(sum_c[l] >> SH);
			end
			swp_s1  <= swp;
			flg_s1  <= flags;
			swp_s2  <= swp_s1;
			flg_s2  <= flg_s1;
			tilt_s3 <= flg_s2.zero ? '0 : sat_c;
			mask_s3 <= flg_s2.zero ? 3'b111 : 3'b000;
		end
	end

	assign out_vld = vld_s3;
	assign tilt    = tilt_s3;
	assign mask    = mask_s3;

endmodule

`default_nettype wire

// File: src/accel_tilt_angles.sv
// ============================================================================
// accel_tilt_angles
// Tilt angles of a three-axis accelerometer sample, fully pipelined.
// ============================================================================
//
// channel   modport          payload                                  transfer
// sample    atilt_in_if      accel_x, accel_y, accel_z (signed)       valid & ready
// angles    atilt_out_if     tilt_x, tilt_y, tilt_z, undefined_mask   valid & ready
//
// one sample per cycle while no result is stalled; stages from sample transfer to result:
// 5 normalize/square, 32 square-root bit stages, 35 cordic, 3 scale
// the whole pipeline advances together when the output register is empty
// or being taken; a stalled result freezes every stage, nothing is dropped
// reset clears only the valid bits; the datapath carries no reset
// ============================================================================
`default_nettype none

module accel_tilt_angles #(
	parameter int ACCEL_WIDTH     = 16,
	parameter int ANGLE_FRAC_BITS = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	atilt_in_if.sink          sample,
	atilt_out_if.source       angles
);

	// global advance: output register free or being drained
	logic en;
	assign en           = !angles.valid || angles.ready;
	assign sample.ready = en;

	logic [2:0][ACCEL_WIDTH-1:0] accel;
	assign accel = {sample.accel_z, sample.accel_y, sample.accel_x};

	// normalized magnitudes and sums of squares
	logic                               nrm_vld;
	logic [2:0][atilt_pkg::SW-1:0]      nrm_rad;
	atilt_pkg::mag3_t                   nrm_mag;
	atilt_pkg::flags_t                  nrm_flg;

	atilt_norm #(
		.ACCEL_WIDTH(ACCEL_WIDTH)
	) u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sample.valid),
		.accel   (accel),
		.out_vld (nrm_vld),
		.rad     (nrm_rad),
		.mag     (nrm_mag),
		.flags   (nrm_flg)
	);

	// lane x: sqrt(y2+z2), lane y: sqrt(x2+z2), lane z: sqrt(x2+y2)
	logic                               sq_vld;
	logic [2:0][atilt_pkg::RTW-1:0]     sq_root;
	atilt_pkg::mag3_t                   sq_mag;
	atilt_pkg::flags_t                  sq_flg;

	atilt_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (nrm_vld),
		.rad       (nrm_rad),
		.mag_in    (nrm_mag),
		.flags_in  (nrm_flg),
		.out_vld   (sq_vld),
		.root      (sq_root),
		.mag_out   (sq_mag),
		.flags_out (sq_flg)
	);

	// x and y angles measure the axis against the other two; z is the reverse
	logic [2:0][atilt_pkg::RTW-1:0]     num, den;
	assign num[0] = atilt_pkg::RTW'(sq_mag[0]);
	assign den[0] = sq_root[0];
	assign num[1] = atilt_pkg::RTW'(sq_mag[1]);
	assign den[1] = sq_root[1];
	assign num[2] = sq_root[2];
	assign den[2] = atilt_pkg::RTW'(sq_mag[2]);

	logic                                     cor_vld;
	logic signed [2:0][atilt_pkg::ACC_W-1:0]  cor_acc;
	logic [2:0]                               cor_swp;
	atilt_pkg::flags_t                        cor_flg;

	atilt_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (sq_vld),
		.num       (num),
		.den       (den),
		.flags_in  (sq_flg),
		.out_vld   (cor_vld),
		.acc       (cor_acc),
		.swp       (cor_swp),
		.flags_out (cor_flg)
	);

	// final stage doubles as the output register
	logic signed [2:0][atilt_pkg::TILT_W-1:0] tilt;
	logic [2:0]                               mask;

	atilt_scale #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (cor_vld),
		.acc     (cor_acc),
		.swp     (cor_swp),
		.flags   (cor_flg),
		.out_vld (angles.valid),
		.tilt    (tilt),
		.mask    (mask)
	);

	assign angles.tilt_x         = tilt[0];
	assign angles.tilt_y         = tilt[1];
	assign angles.tilt_z         = tilt[2];
	assign angles.undefined_mask = mask;

	// largest magnitude a tilt can take
	localparam int TLIM = ((90 << ANGLE_FRAC_BITS) > 32767) ? 32767 : (90 << ANGLE_FRAC_BITS);

	// an undefined result is all three angles at once, all forced to zero
	a_undef_all: assert property (@(posedge clk) disable iff (!arst_n)
		angles.valid && angles.undefined_mask != 3'b000 |->
			angles.undefined_mask == 3'b111 && angles.tilt_x == 0 &&
			angles.tilt_y == 0 && angles.tilt_z == 0)
		else $error("undefined mask inconsistent with tilts");

	// every angle stays within ninety degrees
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		angles.valid |->
			angles.tilt_x <= TLIM && angles.tilt_x >= -TLIM &&
			angles.tilt_y <= TLIM && angles.tilt_y >= -TLIM &&
			angles.tilt_z <= TLIM && angles.tilt_z >= -TLIM)
		else $error("tilt beyond ninety degrees");

	// input is held off only while a finished result is refused
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> angles.valid && !angles.ready)
		else $error("input stalled without output stall");

endmodule

`default_nettype wire

// File: tb/atilt_tb_ifs.sv
`timescale 1ns / 100ps
// ============================================================================
// atilt_tb_ifs
// Testbench-side notes on the sample and angle channels.
// ============================================================================
// the channel interfaces come from the block's own interface file; this file
// only holds the record of one expected angle result for the scoreboard
package atilt_tb_pkg;
	typedef struct {
		logic signed [15:0] tilt_x;
		logic signed [15:0] tilt_y;
		logic signed [15:0] tilt_z;
		logic [2:0]         undefined_mask;
	} angle_set_t;
endpackage

// File: tb/accel_tilt_angles_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// accel_tilt_angles_tb
// Drives accelerometer samples through the tilt pipeline and checks the angles
// against a bit-exact fixed-point predictor (normalize, isqrt, cordic, scale)
// under random sender gaps, receiver stalls, a long hold-off and a drain pause.
// ============================================================================
module accel_tilt_angles_tb;

	localparam int LATENCY = 75;

	// scoreboard of predicted angle sets
	class tilt_scoreboard;
		atilt_tb_pkg::angle_set_t pending[$];
		longint     atan_q34[35];
		int         errors;

		function new();
			int i, k, e;
			longint s;
			errors = 0;
			for (i = 1; i <= 34; i++) begin
				s = 0;
				for (k = 0; ; k++) begin
					e = 62 - i * (2 * k + 1);
					if (e < 0)
						break;
					if (k & 1)
						s -= longint'((64'd1 << e) / (2 * k + 1));
					else
						s += longint'((64'd1 << e) / (2 * k + 1));
				end
				atan_q34[i] = (s + (64'sd1 << 27)) >>> 28;
			end
		endfunction

		function longint unsigned root64(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else
					r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		// angle of n over d in 1/256 degree
		function longint degrees(longint unsigned n, longint unsigned d);
			bit sw;
			longint cx, cy, dx, dy, acc;
			longint unsigned prod, r;
			int i;
			sw = n > d;
			cx = sw ? n << 24 : d << 24;
			cy = sw ? d << 24 : n << 24;
			acc = 0;
			for (i = 1; i <= 34; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cy >= 0) begin
					cx += dx; cy -= dy; acc += atan_q34[i];
				end else begin
					cx -= dx; cy += dy; acc -= atan_q34[i];
				end
			end
			if (acc < 0)
				acc = 0;
			prod = longint'(acc) * 64'd961263669;
			r = (prod + (64'd1 << 49)) >> 50;
			if (sw)
				r = (64'd90 << 8) - r;
			return longint'(r);
		endfunction

		function logic signed [15:0] signed_tilt(longint m, bit neg);
			longint v;
			v = neg ? -m : m;
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			return v[15:0];
		endfunction

		function void note_sample(logic signed [15:0] ax, ay, az);
			atilt_tb_pkg::angle_set_t a;
			longint unsigned ux, uy, uz, m;
			ux = ax < 0 ? -longint'(ax) : ax;
			uy = ay < 0 ? -longint'(ay) : ay;
			uz = az < 0 ? -longint'(az) : az;
			if ((ux | uy | uz) == 0) begin
				a = '{0, 0, 0, 3'b111};
			end else begin
				m = ux > uy ? ux : uy;
				if (uz > m)
					m = uz;
				while (m < (64'd1 << 30)) begin
					ux <<= 1; uy <<= 1; uz <<= 1; m <<= 1;
				end
				while (m >= (64'd1 << 31)) begin
					ux >>= 1; uy >>= 1; uz >>= 1; m >>= 1;
				end
				a.tilt_x = signed_tilt(degrees(ux, root64(uy * uy + uz * uz)), ax < 0);
				a.tilt_y = signed_tilt(degrees(uy, root64(ux * ux + uz * uz)), ay < 0);
				a.tilt_z = signed_tilt(degrees(root64(ux * ux + uy * uy), uz), az < 0);
				a.undefined_mask = 0;
			end
			pending.push_back(a);
		endfunction

		function void check_angles(atilt_tb_pkg::angle_set_t got);
			atilt_tb_pkg::angle_set_t w;
			if (pending.size() == 0) begin
				$display("%0t unexpected result x=%0d y=%0d z=%0d mask=%0d", $time,
					got.tilt_x, got.tilt_y, got.tilt_z, got.undefined_mask);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (got.tilt_x !== w.tilt_x) begin
				$display("%0t tilt_x exp %0d got %0d", $time, w.tilt_x, got.tilt_x);
				errors++;
			end
			if (got.tilt_y !== w.tilt_y) begin
				$display("%0t tilt_y exp %0d got %0d", $time, w.tilt_y, got.tilt_y);
				errors++;
			end
			if (got.tilt_z !== w.tilt_z) begin
				$display("%0t tilt_z exp %0d got %0d", $time, w.tilt_z, got.tilt_z);
				errors++;
			end
			if (got.undefined_mask !== w.undefined_mask) begin
				$display("%0t mask exp %0d got %0d", $time, w.undefined_mask,
					got.undefined_mask);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	bit   hold_off;
	tilt_scoreboard sb;

	atilt_in_if  sample_ch();
	atilt_out_if angles_ch();

	accel_tilt_angles u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch.sink),
		.angles (angles_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver: random stalls, or a full hold-off while hold_off is set
	initial begin
		angles_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			angles_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// result monitor: compare every accepted transfer
	always @(posedge clk) begin
		atilt_tb_pkg::angle_set_t got;
		if (arst_n && angles_ch.valid && angles_ch.ready) begin
			got.tilt_x = angles_ch.tilt_x;
			got.tilt_y = angles_ch.tilt_y;
			got.tilt_z = angles_ch.tilt_z;
			got.undefined_mask = angles_ch.undefined_mask;
			sb.check_angles(got);
		end
	end

	// offer one sample, optionally after random idle cycles, until it transfers
	task automatic send_sample(logic signed [15:0] ax, ay, az);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid   <= 1'b1;
		sample_ch.accel_x <= ax;
		sample_ch.accel_y <= ay;
		sample_ch.accel_z <= az;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		sb.note_sample(ax, ay, az);
	endtask

	task automatic send_random(int count);
		int i, kind;
		logic signed [15:0] ax, ay, az;
		for (i = 0; i < count; i++) begin
			ax = 16'($urandom);
			ay = 16'($urandom);
			az = 16'($urandom);
			kind = $urandom_range(9);
			// small magnitudes and vectors with one zeroed axis exercise normalization
			if (kind == 0) begin
				ax = $signed(ax) >>> $urandom_range(15);
				ay = $signed(ay) >>> $urandom_range(15);
				az = $signed(az) >>> $urandom_range(15);
			end else if (kind == 1) begin
				case ($urandom_range(2))
					0: ax = 0;
					1: ay = 0;
					default: az = 0;
				endcase
			end
			send_sample(ax, ay, az);
		end
		sample_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic signed [15:0] d[$][3];
		sb = new();
		arst_n = 1'b0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		sample_ch.valid = 1'b0;
		sample_ch.accel_x = 0;
		sample_ch.accel_y = 0;
		sample_ch.accel_z = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: all zero, full-scale extremes, zero divisors, octant edges
		d = '{'{0, 0, 0}, '{16'sh7fff, 0, 0}, '{-16'sh8000, 0, 0},
			'{0, 16'sh7fff, 0}, '{0, -16'sh8000, 0}, '{0, 0, 16'sh7fff},
			'{0, 0, -16'sh8000}, '{-16'sh8000, -16'sh8000, -16'sh8000},
			'{16'sh7fff, 16'sh7fff, 16'sh7fff}, '{1, 0, 0}, '{0, 0, -1},
			'{1, 1, 1}, '{-1, 1, -1}, '{100, 100, 0}, '{0, -5, 5},
			'{-16'sh8000, 16'sh7fff, 1}, '{16'sh5555, -16'sh2aab, 16'sh1234}};
		foreach (d[i])
			send_sample(d[i][0], d[i][1], d[i][2]);
		sample_ch.valid <= 1'b0;
		wait_drained();

		send_idle_pct = 11;
		recv_idle_pct = 78;
		send_random(500);

		// long receiver hold-off while samples keep coming, fills the pipeline
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			send_random(150);
		join
		wait_drained();

		send_idle_pct = 78;
		recv_idle_pct = 11;
		send_random(450);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(550);
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end
endmodule
